// ----- rtl/core/lmsc_pkg.sv -----
// ============================================================================
// lmsc_pkg
// Shared types and constants for the LED matrix scan controller.
// ============================================================================
package lmsc_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_START = 2'd3;

    // configuration register indexes (byte address = 4 * index)
    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_LATCH  = 1'b1;

    localparam logic [9:0]  PERIOD_RESET  = 10'd460;
    localparam logic [7:0]  LATCH_RESET   = 8'd5;
    localparam logic [11:0] AMBIENT_LIMIT = 12'd3999;
    localparam logic [8:0]  ON_TIME_CAP   = 9'd500;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  px_x;
        logic [4:0]  px_y;
        logic [1:0]  color;
        logic        pix_value;
        logic [11:0] ambient_level;
    } t_in_word;

    typedef struct packed {
        logic        shift_valid;
        logic [31:0] shift_word;
        logic [3:0]  row_address;
        logic        latch;
        logic        output_enable_n;
        logic        frame_done;
        logic        busy_res;
    } t_out_word;

endpackage

// ----- rtl/core/led_matrix_scan_controller.sv -----
// An accepted word passes through the stage 1 register and then the output register.
// Throughput: one word per cycle unless the output stalls; the store read at
// accept and the stage 1 read-modify-write overlap via a write-forward register.
// Reset: sequencer idle, on/off times zero, period 460, latch 5, every frame
// store row marked invalid (reads as zero) at once; no clearing pass.
// ============================================================================
// led_matrix_scan_controller
// Scan sequencer for an RGB LED matrix with a one-bit-per-pixel frame store.
// ============================================================================
module led_matrix_scan_controller
    import lmsc_pkg::*;
#(
    parameter int LINE_PAIRS   = 16,
    parameter int COLOR_PLANES = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ROW_W  = $clog2(2 * LINE_PAIRS);
    localparam int PL_W   = (COLOR_PLANES > 1) ? $clog2(COLOR_PLANES) : 1;
    localparam int AW     = PL_W + ROW_W;
    localparam int DEPTH  = COLOR_PLANES * (2 ** ROW_W);
    localparam int LINE_W = $clog2(LINE_PAIRS);
    localparam int WI_W   = PL_W + 2;
    localparam int WORDS  = 4 * COLOR_PLANES;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SHIFT,
        PH_LATCH,
        PH_ON,
        PH_OFF
    } t_phase;

    typedef struct packed {
        logic          is_wr;
        logic          is_clr;
        logic [AW-1:0] addr;
        logic [5:0]    bit_idx;
        logic          pix_val;
        logic          sel_low;
        logic          sv;
        logic [3:0]    row_address;
        logic          latch;
        logic          oen;
        logic          done;
        logic          busy;
    } t_s1;

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [9:0] r_period;
    logic [7:0] r_latch_ticks;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= PERIOD_RESET;
            r_latch_ticks <= LATCH_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                CFG_PERIOD: r_period      <= pwdata[9:0];
                CFG_LATCH:  r_latch_ticks <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            CFG_PERIOD: prdata = {22'd0, r_period};
            CFG_LATCH:  prdata = {24'd0, r_latch_ticks};
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------------
    logic r_s1_valid;
    t_s1  r_s1;
    logic s1_fire;
    logic accept;

    assign s1_fire    = r_s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign accept     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    t_phase            r_phase, n_phase;
    logic [LINE_W-1:0] r_line, n_line;
    logic [WI_W-1:0]   r_widx, n_widx;
    logic [9:0]        r_timer, n_timer;
    logic [8:0]        r_on, n_on;
    logic [9:0]        r_off, n_off;

    logic [9:0]        timer_inc;
    logic [WI_W:0]     widx_inc;
    logic [LINE_W:0]   line_inc;
    logic [8:0]        on_calc;
    logic              step_sv;
    logic              step_done;
    logic              do_eol;

    assign timer_inc = r_timer + 10'd1;
    assign widx_inc  = {1'b0, r_widx} + (WI_W + 1)'(1);
    assign line_inc  = {1'b0, r_line} + (LINE_W + 1)'(1);
    assign on_calc   = (i_in.ambient_level > AMBIENT_LIMIT) ? ON_TIME_CAP
                                                            : i_in.ambient_level[11:3];

    always_comb begin
        n_phase   = r_phase;
        n_line    = r_line;
        n_widx    = r_widx;
        n_timer   = r_timer;
        n_on      = r_on;
        n_off     = r_off;
        step_sv   = 1'b0;
        step_done = 1'b0;
        do_eol    = 1'b0;
        unique case (i_in.cmd)
            CMD_START: begin
                if (r_phase == PH_IDLE) begin
                    n_on    = on_calc;
                    n_off   = (r_period > {1'b0, on_calc}) ? r_period - {1'b0, on_calc}
                                                           : 10'd0;
                    n_phase = PH_SHIFT;
                    n_line  = '0;
                    n_widx  = '0;
                    n_timer = '0;
                end
            end
            CMD_TICK: begin
                unique case (r_phase)
                    PH_SHIFT: begin
                        step_sv = 1'b1;
                        n_widx  = widx_inc[WI_W-1:0];
                        if (widx_inc >= (WI_W + 1)'(WORDS)) begin
                            n_widx  = '0;
                            n_timer = '0;
                            n_phase = PH_LATCH;
                        end
                    end
                    PH_LATCH: begin
                        n_timer = timer_inc;
                        if (timer_inc >= {2'b00, r_latch_ticks}) begin
                            n_timer = '0;
                            // zero on or off time skips that phase
                            if (r_on != '0)       n_phase = PH_ON;
                            else if (r_off != '0) n_phase = PH_OFF;
                            else                  do_eol  = 1'b1;
                        end
                    end
                    PH_ON: begin
                        n_timer = timer_inc;
                        if (timer_inc >= {1'b0, r_on}) begin
                            n_timer = '0;
                            if (r_off != '0) n_phase = PH_OFF;
                            else             do_eol  = 1'b1;
                        end
                    end
                    PH_OFF: begin
                        n_timer = timer_inc;
                        if (timer_inc >= r_off) begin
                            n_timer = '0;
                            do_eol  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (do_eol) begin
            n_widx = '0;
            if (line_inc >= (LINE_W + 1)'(LINE_PAIRS)) begin
                n_phase   = PH_IDLE;
                n_line    = '0;
                step_done = 1'b1;
            end else begin
                n_line  = line_inc[LINE_W-1:0];
                n_phase = PH_SHIFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_line  <= '0;
            r_widx  <= '0;
            r_timer <= '0;
            r_on    <= '0;
            r_off   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_line  <= n_line;
            r_widx  <= n_widx;
            r_timer <= n_timer;
            r_on    <= n_on;
            r_off   <= n_off;
        end
    end

    // ------------------------------------------------------------------------
    // frame store addressing
    // ------------------------------------------------------------------------
    logic [PL_W-1:0]  sh_plane;
    logic [ROW_W-1:0] sh_row;
    logic [AW-1:0]    sh_addr;
    logic [AW-1:0]    px_addr;
    logic [AW-1:0]    rd_addr;
    logic             px_ok;

    // word order per plane: bottom high, bottom low, top high, top low
    assign sh_plane = PL_W'(COLOR_PLANES - 1) - r_widx[WI_W-1:2];
    assign sh_row   = r_widx[1] ? ROW_W'(r_line)
                                : ROW_W'(r_line) + ROW_W'(LINE_PAIRS);
    assign sh_addr  = {sh_plane, sh_row};
    assign px_addr  = {PL_W'(i_in.color), ROW_W'(i_in.px_y)};
    assign px_ok    = (i_in.color < 2'(COLOR_PLANES))
                   && ({2'b00, i_in.px_y} < 7'(2 * LINE_PAIRS));
    assign rd_addr  = (i_in.cmd == CMD_WRITE) ? px_addr : sh_addr;

    // ------------------------------------------------------------------------
    // stage 1 register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.is_wr       <= (i_in.cmd == CMD_WRITE) && px_ok;
            r_s1.is_clr      <= (i_in.cmd == CMD_CLEAR);
            r_s1.addr        <= rd_addr;
            r_s1.bit_idx     <= ~i_in.px_x;  // column 0 is bit 63
            r_s1.pix_val     <= i_in.pix_value;
            r_s1.sel_low     <= r_widx[0];
            r_s1.sv          <= step_sv;
            r_s1.row_address <= (r_phase == PH_IDLE) ? 4'd0 : 4'(r_line);
            r_s1.latch       <= (r_phase == PH_LATCH);
            r_s1.oen         <= (r_phase != PH_ON);
            r_s1.done        <= step_done;
            r_s1.busy        <= (n_phase != PH_IDLE);
        end
    end

    // ------------------------------------------------------------------------
    // frame store memory, row valid bits, write forward
    // ------------------------------------------------------------------------
    logic [63:0]    r_frame_mem [DEPTH];
    logic [63:0]    r_mem_q;
    logic [DEPTH-1:0] r_row_valid;
    logic           r_wb_valid;
    logic [AW-1:0]  r_wb_addr;
    logic [63:0]    r_wb_data;
    logic [63:0]    row_data;
    logic [63:0]    row_merged;
    logic           fwd_hit;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_q <= r_frame_mem[rd_addr];
        end
        if (s1_fire && r_s1.is_wr) begin
            r_frame_mem[r_s1.addr] <= row_merged;
        end
    end

    // the write issued by the word ahead lands at the edge this word's read
    // was taken, so that row comes from the forward register
    assign fwd_hit = r_wb_valid && (r_wb_addr == r_s1.addr);

    always_comb begin
        if (fwd_hit) begin
            row_data = r_wb_data;
        end else if (r_row_valid[r_s1.addr]) begin
            row_data = r_mem_q;
        end else begin
            row_data = '0;
        end
        row_merged                 = row_data;
        row_merged[r_s1.bit_idx]   = r_s1.pix_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_wb_valid  <= 1'b0;
        end else if (s1_fire) begin
            if (r_s1.is_clr) begin
                r_row_valid <= '0;
                r_wb_valid  <= 1'b0;
            end else if (r_s1.is_wr) begin
                r_row_valid[r_s1.addr] <= 1'b1;
                r_wb_valid             <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.is_wr) begin
            r_wb_addr <= r_s1.addr;
            r_wb_data <= row_merged;
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    logic      r_out_valid;
    t_out_word r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out.shift_valid     <= r_s1.sv;
            r_out.shift_word      <= !r_s1.sv    ? 32'd0
                                   : r_s1.sel_low ? row_data[31:0] : row_data[63:32];
            r_out.row_address     <= r_s1.row_address;
            r_out.latch           <= r_s1.latch;
            r_out.output_enable_n <= r_s1.oen;
            r_out.frame_done      <= r_s1.done;
            r_out.busy_res        <= r_s1.busy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- rtl/core/lmsc_checker.sv -----
// ============================================================================
// lmsc_checker
// Port-level checks on the scan controller's result words.
// ============================================================================
module lmsc_checker
    import lmsc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result word changed while stalled");

    // latch strobe and lit LEDs never overlap
    a_latch_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.latch && !o_out.output_enable_n))
        else $error("latch high while output enabled");

    // shifting happens only inside a frame, with the panel dark and unlatched
    a_shift_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.shift_valid |->
            o_out.busy_res && !o_out.latch && o_out.output_enable_n)
        else $error("shift word outside shift phase");

    // the end of a frame leaves the sequencer idle and sends no data
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.frame_done |->
            !o_out.busy_res && !o_out.shift_valid && (o_out.shift_word == 32'd0))
        else $error("frame done while still busy");

endmodule

bind led_matrix_scan_controller lmsc_checker u_lmsc_checker (.*);

// ----- sim/tb_led_matrix_scan_controller.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED matrix scan controller testbench
// Drives pixel writes, clears, frame starts and ticks into the block with
// random gaps and output stalls. A tracker class follows the scan sequencer
// and frame store and checks every output word field by field. The register
// port is written between phases, mid-frame included, and read back.
// ----------------------------------------------------------------------------

class panel_scan_tracker #(int LINE_PAIRS = 16, int COLOR_PLANES = 3);

    typedef enum bit [2:0] {SEQ_IDLE, SEQ_SHIFT, SEQ_LATCH, SEQ_ON, SEQ_OFF} t_seq;

    bit [63:0] pixels [COLOR_PLANES][2*LINE_PAIRS];
    t_seq      seq;
    bit [3:0]  line;
    bit [3:0]  word_idx;
    bit [9:0]  timer;
    bit [8:0]  on_ticks;
    bit [9:0]  off_ticks;
    bit [9:0]  period;
    bit [7:0]  latch_len;
    lmsc_pkg::t_out_word pending_outputs[$];
    int        errors;

    function new();
        foreach (pixels[p, r]) pixels[p][r] = '0;
        seq       = SEQ_IDLE;
        line      = '0;
        word_idx  = '0;
        timer     = '0;
        on_ticks  = '0;
        off_ticks = '0;
        period    = lmsc_pkg::PERIOD_RESET;
        latch_len = lmsc_pkg::LATCH_RESET;
        errors    = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
        if (idx == lmsc_pkg::CFG_PERIOD) period = value[9:0];
        else latch_len = value[7:0];
    endfunction

    function bit busy();
        return seq != SEQ_IDLE;
    endfunction

    function int pending();
        return pending_outputs.size();
    endfunction

    // returns 1 when the last line pair of the frame has just finished
    function bit end_line();
        timer    = '0;
        word_idx = '0;
        if (int'(line) + 1 >= LINE_PAIRS) begin
            seq  = SEQ_IDLE;
            line = '0;
            return 1'b1;
        end
        line++;
        seq = SEQ_SHIFT;
        return 1'b0;
    endfunction

    function bit enter_off();
        timer = '0;
        if (off_ticks != 0) begin
            seq = SEQ_OFF;
            return 1'b0;
        end
        return end_line();
    endfunction

    function void accept_command(lmsc_pkg::t_in_word w);
        lmsc_pkg::t_out_word want;
        int plane;
        int row;
        want = '0;
        // level outputs show the phase before this step moves it
        want.row_address     = (seq == SEQ_IDLE) ? 4'd0 : line;
        want.latch           = (seq == SEQ_LATCH);
        want.output_enable_n = (seq != SEQ_ON);
        case (w.cmd)
            lmsc_pkg::CMD_WRITE: begin
                if (int'(w.color) < COLOR_PLANES && int'(w.px_y) < 2*LINE_PAIRS)
                    pixels[w.color][w.px_y][63 - int'(w.px_x)] = w.pix_value;
            end
            lmsc_pkg::CMD_CLEAR: begin
                foreach (pixels[p, r]) pixels[p][r] = '0;
            end
            lmsc_pkg::CMD_START: begin
                if (seq == SEQ_IDLE) begin
                    on_ticks  = (w.ambient_level > lmsc_pkg::AMBIENT_LIMIT) ?
                                lmsc_pkg::ON_TIME_CAP : w.ambient_level[11:3];
                    off_ticks = (period > 10'(on_ticks)) ? period - 10'(on_ticks) : '0;
                    seq       = SEQ_SHIFT;
                    line      = '0;
                    word_idx  = '0;
                    timer     = '0;
                end
            end
            default: begin
                case (seq)
                    SEQ_SHIFT: begin
                        // blue, green, red; bottom row first, high half first
                        plane = COLOR_PLANES - 1 - int'(word_idx[3:2]);
                        row   = word_idx[1] ? int'(line) : int'(line) + LINE_PAIRS;
                        want.shift_valid = 1'b1;
                        want.shift_word  = word_idx[0] ? pixels[plane][row][31:0]
                                                       : pixels[plane][row][63:32];
                        word_idx++;
                        if (int'(word_idx) >= 4*COLOR_PLANES) begin
                            word_idx = '0;
                            timer    = '0;
                            seq      = SEQ_LATCH;
                        end
                    end
                    SEQ_LATCH: begin
                        timer++;
                        if (timer >= 10'(latch_len)) begin
                            timer = '0;
                            if (on_ticks != 0) seq = SEQ_ON;
                            else want.frame_done = enter_off();
                        end
                    end
                    SEQ_ON: begin
                        timer++;
                        if (timer >= 10'(on_ticks)) want.frame_done = enter_off();
                    end
                    SEQ_OFF: begin
                        timer++;
                        if (timer >= off_ticks) want.frame_done = end_line();
                    end
                    default: ;
                endcase
            end
        endcase
        want.busy_res = (seq != SEQ_IDLE);
        pending_outputs.push_back(want);
    endfunction

    function void mismatch(string field, logic [31:0] want, logic [31:0] got);
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
    endfunction

    function void check_output(lmsc_pkg::t_out_word got);
        lmsc_pkg::t_out_word want;
        if (pending_outputs.size() == 0) begin
            $error("output word %h with none pending", got);
            errors++;
            return;
        end
        want = pending_outputs.pop_front();
        if (got.shift_valid !== want.shift_valid)
            mismatch("shift_valid", want.shift_valid, got.shift_valid);
        if (got.shift_word !== want.shift_word)
            mismatch("shift_word", want.shift_word, got.shift_word);
        if (got.row_address !== want.row_address)
            mismatch("row_address", want.row_address, got.row_address);
        if (got.latch !== want.latch)
            mismatch("latch", want.latch, got.latch);
        if (got.output_enable_n !== want.output_enable_n)
            mismatch("output_enable_n", want.output_enable_n, got.output_enable_n);
        if (got.frame_done !== want.frame_done)
            mismatch("frame_done", want.frame_done, got.frame_done);
        if (got.busy_res !== want.busy_res)
            mismatch("busy_res", want.busy_res, got.busy_res);
    endfunction

endclass

module tb_led_matrix_scan_controller;
    import lmsc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_WORDS = 1000;
    localparam int TAIL_CYCLES  = 8;
    localparam int TIMEOUT_NS   = 20_000_000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in        = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_word   o_out;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    panel_scan_tracker tracker;
    int words_sent  = 0;
    bit tx_idle_en  = 1'b1;
    bit rx_stall_en = 1'b1;

    led_matrix_scan_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_in_word make_word(logic [1:0] cmd, logic [5:0] x, logic [4:0] y,
                                           logic [1:0] color, logic value,
                                           logic [11:0] ambient);
        t_in_word w;
        w.cmd           = cmd;
        w.px_x          = x;
        w.px_y          = y;
        w.color         = color;
        w.pix_value     = value;
        w.ambient_level = ambient;
        return w;
    endfunction

    function automatic t_in_word rand_word();
        logic [27:0] raw;
        int unsigned r;
        t_in_word w;
        raw = 28'($urandom);
        r   = $urandom_range(0, 99);
        w   = raw;
        if (r < 86) w.cmd = CMD_TICK;
        else if (r < 95) w.cmd = CMD_WRITE;
        else if (r < 96) w.cmd = CMD_CLEAR;
        else w.cmd = CMD_START;
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        i_in_valid <= 1'b1;
        i_in       <= w;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.accept_command(w);
        words_sent++;
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // write one register, then read it back
    task automatic cfg_write(input logic idx, input logic [31:0] value);
        logic [31:0] want;
        want    = (idx == CFG_PERIOD) ? {22'b0, value[9:0]} : {24'b0, value[7:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) tracker.mismatch("prdata", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // one frame: set up registers, start, then tick it through with pixel
    // traffic mixed in; at most one pause mid-frame to change registers live
    task automatic run_frame(input logic [9:0] per, input logic [7:0] lat,
                             input logic [11:0] amb, input logic [7:0] mid_lat,
                             input int budget);
        t_in_word w;
        int n;
        int pause_at;
        tx_idle_en  = ($urandom_range(0, 3) != 0);
        rx_stall_en = ($urandom_range(0, 3) != 0);
        pause_at    = $urandom_range(0, 300);
        drain();
        cfg_write(CFG_PERIOD, {22'b0, per});
        cfg_write(CFG_LATCH, {24'b0, lat});
        w = rand_word();
        w.cmd = CMD_START;
        w.ambient_level = amb;
        send_word(w);
        n = 0;
        while (tracker.busy() && n < budget) begin
            if (n == pause_at) begin
                drain();
                cfg_write(CFG_LATCH, {24'b0, mid_lat});
                cfg_write(CFG_PERIOD, 32'($urandom_range(0, 1023)));
            end
            hold_off(tx_idle_en ? pick_gap() : 0);
            send_word(rand_word());
            n++;
        end
        // idle noise, never a start
        repeat ($urandom_range(0, 4)) begin
            w = rand_word();
            if (w.cmd == CMD_START) w.cmd = CMD_TICK;
            hold_off(tx_idle_en ? pick_gap() : 0);
            send_word(w);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) tracker.check_output(o_out);
    end

    initial begin
        forever begin
            repeat ($urandom_range(1, 40)) @(posedge i_clk) i_out_ready <= 1'b1;
            repeat (rx_stall_en ? pick_gap() : 0) @(posedge i_clk) i_out_ready <= 1'b0;
        end
    end

    initial begin
        tracker = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle behavior, store corners, missing plane, clear
        send_word(make_word(CMD_TICK, 6'd0, 5'd0, 2'd0, 1'b0, 12'd0));
        send_word(make_word(CMD_WRITE, 6'd0, 5'd0, 2'd0, 1'b1, 12'hfff));
        send_word(make_word(CMD_WRITE, 6'd63, 5'd31, 2'd2, 1'b1, 12'd0));
        send_word(make_word(CMD_WRITE, 6'd31, 5'd16, 2'd1, 1'b1, 12'd0));
        send_word(make_word(CMD_WRITE, 6'd32, 5'd15, 2'd0, 1'b1, 12'd0));
        send_word(make_word(CMD_WRITE, 6'd5, 5'd5, 2'd3, 1'b1, 12'd0));
        send_word(make_word(CMD_WRITE, 6'd63, 5'd31, 2'd2, 1'b0, 12'd0));
        send_word(make_word(CMD_CLEAR, 6'd63, 5'd31, 2'd3, 1'b1, 12'hfff));
        send_word(make_word(CMD_TICK, 6'd63, 5'd31, 2'd3, 1'b1, 12'hfff));
        send_word(make_word(CMD_WRITE, 6'd0, 5'd16, 2'd2, 1'b1, 12'd0));
        send_word(make_word(CMD_WRITE, 6'd63, 5'd0, 2'd0, 1'b1, 12'd0));
        send_word(make_word(CMD_WRITE, 6'd63, 5'd31, 2'd1, 1'b1, 12'd0));
        send_word(make_word(CMD_WRITE, 6'd0, 5'd15, 2'd2, 1'b1, 12'd0));

        // no on time and no blank time, zero latch length
        run_frame(10'd0, 8'd0, 12'd7, 8'd0, 1000);
        // on time equal to the period: blank skipped
        run_frame(10'd8, 8'd1, 12'd64, 8'd2, 1000);
        // dark frame: no on time
        run_frame(10'd10, 8'd2, 12'd0, 8'd1, 1000);

        while (words_sent < RANDOM_WORDS)
            run_frame(10'($urandom_range(0, 30)), 8'($urandom_range(0, 4)),
                      12'($urandom_range(0, 250)), 8'($urandom_range(0, 6)), 1000);

        // capped on time, longest latch and period; first line pair only
        run_frame(10'd1023, 8'd255, 12'd4000, 8'd255, 400);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
